/* rtl/core/spmv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse matrix-vector multiply package
// Shared widths, opcodes and the control bundle of the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package spmv_pkg;

  localparam int IdxW = 12;
  localparam int ValW = 32;
  localparam int SumW = 64;
  localparam int RowW = 12;
  localparam int OpW  = 2;

  localparam int VectorDepthDef = 4096;

  localparam logic [OpW-1:0] OP_LOAD    = 2'd0;
  localparam logic [OpW-1:0] OP_NONZERO = 2'd1;
  localparam logic [OpW-1:0] OP_END_ROW = 2'd2;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic clr_en;
  } spmv_ctl_t;

endpackage

/* rtl/core/spmv_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Single-port RAM
// Generic synchronous RAM with one access per cycle and a registered read.
// ----------------------------------------------------------------------------
module spmv_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             req_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/spmv_mac.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiply-accumulate unit
// Registered Q32.32 product of Q16.16 operands and a saturating Q32.32 running row sum.
// ----------------------------------------------------------------------------
module spmv_mac
  import spmv_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  spmv_ctl_t              ctl_i,
  input  logic signed [ValW-1:0] a_i,
  input  logic signed [ValW-1:0] b_i,
  output logic signed [SumW-1:0] sum_o
);

  logic signed [SumW-1:0] prod_q;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic signed [SumW-1:0] raw_sum;
  logic                   ovf;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= SumW'(a_i * b_i);
    end
  end

  assign raw_sum = sum_q + prod_q;
  assign ovf     = (sum_q[SumW-1] == prod_q[SumW-1]) && (raw_sum[SumW-1] != sum_q[SumW-1]);

  always_comb begin
    sum_d = sum_q;
    if (ctl_i.clr_en) begin
      sum_d = '0;
    end else if (ctl_i.acc_en) begin
      if (ovf) begin
        sum_d = sum_q[SumW-1] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
      end else begin
        sum_d = raw_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

/* rtl/core/sparse_matrix_vector_multiply.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse matrix-vector multiply
// Computes b = A*x from a compressed-row stream of vector loads, nonzeros and
// end-of-row marks, with Q16.16 operands and a saturating Q32.32 row sum.
//
//   Channel | Direction | Fields
//   in      | input     | in_op_i, in_index_i, in_value_i
//   out     | output    | out_row_number_o, out_row_sum_o
//
// A vector load, an end-of-row mark and an unused opcode do not leave the idle state.
// A nonzero steps through vector RAM read, multiply and accumulate.
// An end-of-row mark waits while the output register holds an untaken result.
// Reset clears the row sum, the row counter and the output valid; the vector
// store holds no defined value until it is loaded.
// ----------------------------------------------------------------------------
module sparse_matrix_vector_multiply
  import spmv_pkg::*;
#(
  parameter int VectorDepth = VectorDepthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [OpW-1:0]         in_op_i,
  input  logic [IdxW-1:0]        in_index_i,
  input  logic signed [ValW-1:0] in_value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [RowW-1:0]        out_row_number_o,
  output logic signed [SumW-1:0] out_row_sum_o
);

  localparam int AddrW = (VectorDepth > 1) ? $clog2(VectorDepth) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [RowW-1:0]        row_q, row_d;
  logic                   out_valid_q, out_valid_d;
  logic [RowW-1:0]        out_row_q;
  logic signed [SumW-1:0] out_sum_q;
  logic signed [ValW-1:0] val_q;
  logic                   in_fire;
  logic                   in_range;
  logic                   ram_req;
  logic                   ram_we;
  logic [ValW-1:0]        ram_rdata;
  logic signed [SumW-1:0] sum;
  spmv_ctl_t              ctl;

  assign in_range   = 32'(in_index_i) < 32'(VectorDepth);
  assign in_ready_o = (state_q == ST_IDLE) &&
                      ((in_op_i != OP_END_ROW) || !out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  assign ram_we  = in_fire && (in_op_i == OP_LOAD) && in_range;
  assign ram_req = in_fire && ((in_op_i == OP_LOAD) || (in_op_i == OP_NONZERO)) && in_range;

  spmv_ram #(
    .Width(ValW),
    .Depth(VectorDepth)
  ) u_vec_ram (
    .clk_i  (clk_i),
    .req_i  (ram_req),
    .we_i   (ram_we),
    .addr_i (AddrW'(in_index_i)),
    .wdata_i(in_value_i),
    .rdata_o(ram_rdata)
  );

  assign ctl.mul_en = (state_q == ST_READ);
  assign ctl.acc_en = (state_q == ST_ACC);
  assign ctl.clr_en = in_fire && (in_op_i == OP_END_ROW);

  spmv_mac u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (ctl),
    .a_i   (val_q),
    .b_i   (ram_rdata),
    .sum_o (sum)
  );

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op_i)
            OP_LOAD: begin
              row_d = '0;
            end
            OP_NONZERO: begin
              if (in_range) begin
                state_d = ST_READ;
              end
            end
            OP_END_ROW: begin
              out_valid_d = 1'b1;
              row_d       = row_q + 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      val_q <= in_value_i;
    end
    if (in_fire && (in_op_i == OP_END_ROW)) begin
      out_row_q <= row_q;
      out_sum_q <= sum;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_row_number_o = out_row_q;
  assign out_row_sum_o    = out_sum_q;

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE)
    else $error("Input ready outside the idle state.");

  a_read_then_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> state_q == ST_ACC)
    else $error("Nonzero sequence broken after the vector read.");

  a_end_row_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_op_i == OP_END_ROW |=>
      out_valid_o && out_row_number_o == $past(row_q) && sum == '0)
    else $error("End-of-row transaction did not produce its result.");

  a_load_clears_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_op_i == OP_LOAD |=> row_q == '0)
    else $error("Vector load did not clear the row counter.");

endmodule

/* tb/sv/tb_sparse_matrix_vector_multiply.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse matrix-vector multiply testbench
// Drives vector loads, nonzeros and end-of-row marks through the valid/ready
// input and checks every row result against a behavioral model kept in step
// with each accepted transaction, or the expected value of a directed row.
// The short directed table covers operand extremes, saturation both ways,
// empty rows and the load's row reset. Random phases vary the idle patterns.
// ----------------------------------------------------------------------------
module tb_sparse_matrix_vector_multiply;
  import spmv_pkg::*;

  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;
  localparam int CycleLimit = 400000;
  localparam int ItemsPerPhase = 525;
  localparam int DirectedCount = 22;
  localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  typedef struct packed {
    logic [RowW-1:0]        row;
    logic signed [SumW-1:0] sum;
  } row_result_t;

  typedef struct packed {
    logic [OpW-1:0]  op;
    logic [IdxW-1:0] idx;
    logic [ValW-1:0] val;
    logic            known;
    logic [RowW-1:0] exp_row;
    logic [SumW-1:0] exp_sum;
  } stim_t;

  stim_t directed_rows [DirectedCount] = '{
    '{OP_END_ROW, 12'h000, 32'h0000_0000, 1'b1, 12'd0, 64'h0000_0000_0000_0000},
    '{OP_LOAD,    12'h000, 32'h7FFF_FFFF, 1'b0, 12'd0, 64'h0},
    '{OP_LOAD,    12'hFFF, 32'h8000_0000, 1'b0, 12'd0, 64'h0},
    '{OP_LOAD,    12'h001, 32'h0001_0000, 1'b0, 12'd0, 64'h0},
    '{OP_LOAD,    12'h002, 32'hFFFF_FFFF, 1'b0, 12'd0, 64'h0},
    '{OP_NONZERO, 12'h000, 32'h7FFF_FFFF, 1'b0, 12'd0, 64'h0},
    '{OP_END_ROW, 12'hFFF, 32'hFFFF_FFFF, 1'b1, 12'd0, 64'h3FFF_FFFF_0000_0001},
    '{OP_NONZERO, 12'hFFF, 32'h8000_0000, 1'b0, 12'd0, 64'h0},
    '{OP_NONZERO, 12'hFFF, 32'h8000_0000, 1'b0, 12'd0, 64'h0},
    '{OP_END_ROW, 12'h000, 32'h0000_0000, 1'b1, 12'd1, 64'h7FFF_FFFF_FFFF_FFFF},
    '{OP_NONZERO, 12'hFFF, 32'h7FFF_FFFF, 1'b0, 12'd0, 64'h0},
    '{OP_NONZERO, 12'hFFF, 32'h7FFF_FFFF, 1'b0, 12'd0, 64'h0},
    '{OP_NONZERO, 12'hFFF, 32'h7FFF_FFFF, 1'b0, 12'd0, 64'h0},
    '{OP_END_ROW, 12'h000, 32'h0000_0000, 1'b1, 12'd2, 64'h8000_0000_0000_0000},
    '{OP_UNUSED,  12'hABC, 32'h5A5A_5A5A, 1'b0, 12'd0, 64'h0},
    '{OP_NONZERO, 12'h001, 32'h0002_0000, 1'b0, 12'd0, 64'h0},
    '{OP_NONZERO, 12'h002, 32'hFFFF_FFFF, 1'b0, 12'd0, 64'h0},
    '{OP_END_ROW, 12'h000, 32'h0000_0000, 1'b1, 12'd3, 64'h0000_0002_0000_0001},
    '{OP_END_ROW, 12'h000, 32'h0000_0000, 1'b1, 12'd4, 64'h0000_0000_0000_0000},
    '{OP_NONZERO, 12'h001, 32'h0001_0000, 1'b0, 12'd0, 64'h0},
    '{OP_LOAD,    12'h003, 32'h1234_5678, 1'b0, 12'd0, 64'h0},
    '{OP_END_ROW, 12'h000, 32'h0000_0000, 1'b1, 12'd0, 64'h0000_0001_0000_0000}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [OpW-1:0]         in_op_i = OP_LOAD;
  logic [IdxW-1:0]        in_index_i = '0;
  logic signed [ValW-1:0] in_value_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [RowW-1:0]        out_row_number_o;
  logic signed [SumW-1:0] out_row_sum_o;

  logic signed [ValW-1:0] x_model [VectorDepthDef];
  bit                     x_loaded [VectorDepthDef];
  int                     loaded_idx [$];
  logic signed [SumW-1:0] acc_model = '0;
  logic [RowW-1:0]        row_model = '0;
  row_result_t            row_sums_due [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  sparse_matrix_vector_multiply uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_op_i          (in_op_i),
    .in_index_i       (in_index_i),
    .in_value_i       (in_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_row_number_o (out_row_number_o),
    .out_row_sum_o    (out_row_sum_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string what, input logic [SumW-1:0] got,
                                 input logic [SumW-1:0] want);
    $display("mismatch: %s got %h expected %h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  function automatic void predict_row_sum(input stim_t it);
    logic signed [SumW-1:0] prod;
    logic signed [SumW-1:0] total;
    row_result_t res;
    case (it.op)
      OP_LOAD: begin
        if (int'(it.idx) < VectorDepthDef) begin
          x_model[it.idx] = it.val;
          if (!x_loaded[it.idx]) begin
            x_loaded[it.idx] = 1'b1;
            loaded_idx.push_back(int'(it.idx));
          end
        end
        row_model = '0;
      end
      OP_NONZERO: begin
        prod = '0;
        if (int'(it.idx) < VectorDepthDef) begin
          prod = longint'($signed(it.val)) * longint'(x_model[it.idx]);
        end
        total = acc_model + prod;
        if (acc_model[SumW-1] == prod[SumW-1] && total[SumW-1] != acc_model[SumW-1]) begin
          total = acc_model[SumW-1] ? SumMin : SumMax;
        end
        acc_model = total;
      end
      OP_END_ROW: begin
        if (it.known) begin
          res.row = it.exp_row;
          res.sum = it.exp_sum;
        end else begin
          res.row = row_model;
          res.sum = acc_model;
        end
        row_sums_due.push_back(res);
        acc_model = '0;
        row_model = row_model + 1'b1;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [ValW-1:0] random_value();
    int pick;
    pick = $urandom_range(0, 7);
    case (pick)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic stim_t random_item();
    stim_t it;
    int pick;
    it = '0;
    it.idx = IdxW'($urandom_range(0, VectorDepthDef - 1));
    it.val = random_value();
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      it.op = OP_LOAD;
    end else if (pick < 10) begin
      it.op = OP_UNUSED;
    end else if (pick < 32) begin
      it.op = OP_END_ROW;
    end else begin
      it.op = OP_NONZERO;
      it.idx = IdxW'(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)]);
    end
    return it;
  endfunction

  task automatic send_item(input stim_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_op_i    <= it.op;
    in_index_i <= it.idx;
    in_value_i <= it.val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_row_sum(it);
  endtask

  task automatic run_random(input int count);
    stim_t it;
    int sent;
    sent = 0;
    while (sent < count) begin
      it = random_item();
      send_item(it);
      if (it.op != OP_UNUSED) sent++;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (row_sums_due.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : check_result
    row_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (row_sums_due.size() == 0) begin
        report_mismatch("unexpected row result", SumW'(out_row_number_o), '0);
      end else begin
        want = row_sums_due.pop_front();
        if (out_row_number_o !== want.row) begin
          report_mismatch("row number", SumW'(out_row_number_o), SumW'(want.row));
        end
        if (out_row_sum_o !== want.sum) begin
          report_mismatch("row sum", out_row_sum_o, want.sum);
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 9;
    recv_idle_pct = 55;
    foreach (directed_rows[i]) send_item(directed_rows[i]);
    run_random(ItemsPerPhase);
    wait_drained();

    send_idle_pct = 55;
    recv_idle_pct = 9;
    run_random(ItemsPerPhase);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(ItemsPerPhase);

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/spmv_pkg.sv
rtl/core/spmv_ram.sv
rtl/core/spmv_mac.sv
rtl/core/sparse_matrix_vector_multiply.sv
tb/sv/tb_sparse_matrix_vector_multiply.sv
